// ===== rtl/pdm_pkg.sv =====
// Shared types, codes and microcode program of the differential-drive PD mixer.
package pdm_pkg;

    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;
    localparam int STEP_W = 3;
    localparam int PROD_W = 34;
    localparam int PID_W  = 35;
    localparam int SUM_W  = 38;
    localparam int ACC_W  = 48;
    localparam int VAL_W  = 32;
    localparam int DRV_W  = 11;

    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_BASE_SPEED = 2'd2;
    localparam logic [IDX_W-1:0] REG_DERIV_IVL  = 2'd3;

    localparam logic [CFG_W-1:0] PROP_GAIN_RST  = 16'd25600;
    localparam logic [CFG_W-1:0] DERIV_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] BASE_SPEED_RST = 16'd12800;
    localparam logic [CFG_W-1:0] DERIV_IVL_RST  = 16'd0;

    // 50.0 in Q16.16
    localparam logic signed [ACC_W-1:0] DRIVE_OFFSET = 48'sd3276800;

    localparam logic [2:0] OP_TEST  = 3'd0;
    localparam logic [2:0] OP_UPD   = 3'd1;
    localparam logic [2:0] OP_MULKD = 3'd2;
    localparam logic [2:0] OP_PID   = 3'd3;
    localparam logic [2:0] OP_SUM   = 3'd4;
    localparam logic [2:0] OP_SCALE = 3'd5;
    localparam logic [2:0] OP_CLAMP = 3'd6;
    localparam logic [2:0] OP_OUT   = 3'd7;

    localparam logic [1:0] JC_NONE    = 2'd0;
    localparam logic [1:0] JC_NOT_DUE = 2'd1;
    localparam logic [1:0] JC_SIDE_L  = 2'd2;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        jc;
        logic [STEP_W-1:0] tgt;
        logic              last;
    } t_ctrl;

    typedef struct packed {
        logic due;
        logic side;
    } t_stat;

    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        w = '{op: OP_OUT, jc: JC_NONE, tgt: 3'd0, last: 1'b1};
        case (step)
            3'd0:    w = '{op: OP_TEST,  jc: JC_NOT_DUE, tgt: 3'd2, last: 1'b0};
            3'd1:    w = '{op: OP_UPD,   jc: JC_NONE,    tgt: 3'd0, last: 1'b0};
            3'd2:    w = '{op: OP_MULKD, jc: JC_NONE,    tgt: 3'd0, last: 1'b0};
            3'd3:    w = '{op: OP_PID,   jc: JC_NONE,    tgt: 3'd0, last: 1'b0};
            3'd4:    w = '{op: OP_SUM,   jc: JC_NONE,    tgt: 3'd0, last: 1'b0};
            3'd5:    w = '{op: OP_SCALE, jc: JC_NONE,    tgt: 3'd0, last: 1'b0};
            3'd6:    w = '{op: OP_CLAMP, jc: JC_SIDE_L,  tgt: 3'd4, last: 1'b0};
            3'd7:    w = '{op: OP_OUT,   jc: JC_NONE,    tgt: 3'd0, last: 1'b1};
            default: w = '{op: OP_OUT,   jc: JC_NONE,    tgt: 3'd0, last: 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pdm_seq.sv =====
// Microcode sequencer: step counter, program table lookup and conditional jumps.
module pdm_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_hold,
    input  pdm_pkg::t_stat i_stat,
    output pdm_pkg::t_ctrl o_ctrl,
    output logic           o_en,
    output logic           o_busy
);
    import pdm_pkg::*;

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_step, n_step;
    t_ctrl             ctrl;
    logic              en;
    logic              jump;

    always_comb begin
        ctrl = ucode(r_step);
        en   = r_busy && !(ctrl.op == OP_OUT && i_hold);
        jump = (ctrl.jc == JC_NOT_DUE && !i_stat.due) ||
               (ctrl.jc == JC_SIDE_L && !i_stat.side);
    end

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_step = '0;
            end
        end else if (en) begin
            if (ctrl.last) begin
                n_busy = 1'b0;
            end else if (jump) begin
                n_step = ctrl.tgt;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;
    assign o_en   = en;
    assign o_busy = r_busy;

endmodule

// ===== rtl/pdm_dp.sv =====
// Datapath: configuration, derivative state, shared multiplier, mixer and clamp.
module pdm_dp #(
    parameter int DERIV_INTERVAL_CAP = 190,
    parameter int DRIVE_LIMIT        = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pdm_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [pdm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_load,
    input  logic signed [15:0]                i_line_error,
    input  logic signed [15:0]                i_speed_left,
    input  logic signed [15:0]                i_speed_right,
    input  logic [31:0]                       i_now_ms,
    input  pdm_pkg::t_ctrl                    i_ctrl,
    input  logic                              i_en,
    output pdm_pkg::t_stat                    o_stat,
    output logic signed [pdm_pkg::DRV_W-1:0]  o_drive_left,
    output logic signed [pdm_pkg::DRV_W-1:0]  o_drive_right,
    output logic                              o_deriv_updated,
    output logic                              o_saturated
);
    import pdm_pkg::*;

    localparam logic [CFG_W-1:0]        CAP_V = CFG_W'(DERIV_INTERVAL_CAP);
    localparam logic signed [VAL_W-1:0] LIM_P = VAL_W'(DRIVE_LIMIT);
    localparam logic signed [VAL_W-1:0] LIM_N = -LIM_P;

    logic [CFG_W-1:0] r_kp, r_kd, r_base, r_ivl;

    logic signed [15:0] r_err, r_ml, r_mr;
    logic [31:0]        r_now;

    logic signed [15:0] r_prev_err;
    logic signed [16:0] r_dterm;
    logic [31:0]        r_last_t;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PID_W-1:0]  r_pid;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DRV_W-1:0]  r_drv_l, r_drv_r;
    logic                     r_side, r_upd, r_sat;

    logic signed [DRV_W-1:0]  r_out_l, r_out_r;
    logic                     r_out_upd, r_out_sat;

    logic [CFG_W-1:0]         ivl_used;
    logic [31:0]              due_t;
    logic                     due;
    logic signed [16:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [SUM_W-1:0]  pid_x, pid3, meas, base2, sum;
    logic signed [ACC_W-1:0]  acc_x, scaled;
    logic signed [VAL_W-1:0]  flr, val, clamped;
    logic                     clip;

    always_comb begin
        ivl_used = (r_ivl > CAP_V) ? CAP_V : r_ivl;
        due_t    = r_last_t + {16'd0, ivl_used};
        due      = due_t < r_now;
    end

    always_comb begin
        if (i_ctrl.op == OP_TEST) begin
            mul_a = $signed({1'b0, r_kp});
            mul_b = 17'(r_err);
        end else begin
            mul_a = $signed({1'b0, r_kd});
            mul_b = r_dterm;
        end
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        pid_x = SUM_W'(r_pid);
        pid3  = (pid_x <<< 1) + pid_x;
        meas  = SUM_W'(r_side ? r_mr : r_ml) <<< 8;
        base2 = $signed({{(SUM_W - CFG_W - 9){1'b0}}, r_base, 9'd0});
        sum   = r_side ? (base2 - pid3 - meas) : (base2 + pid3 - meas);
    end

    always_comb begin
        acc_x  = r_acc;
        scaled = (acc_x <<< 8) - (acc_x <<< 5) - (acc_x <<< 2) + DRIVE_OFFSET;
    end

    always_comb begin
        flr = VAL_W'(r_acc >>> 16);
        val = flr + $signed({{(VAL_W - 1){1'b0}}, (r_acc[ACC_W-1] && (|r_acc[15:0]))});
        clip    = 1'b0;
        clamped = val;
        if (val > LIM_P) begin
            clamped = LIM_P;
            clip    = 1'b1;
        end else if (val < LIM_N) begin
            clamped = LIM_N;
            clip    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= PROP_GAIN_RST;
            r_kd   <= DERIV_GAIN_RST;
            r_base <= BASE_SPEED_RST;
            r_ivl  <= DERIV_IVL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:  r_kp   <= i_cfg_data;
                REG_DERIV_GAIN: r_kd   <= i_cfg_data;
                REG_BASE_SPEED: r_base <= i_cfg_data;
                REG_DERIV_IVL:  r_ivl  <= i_cfg_data;
                default:        r_ivl  <= r_ivl;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_dterm    <= '0;
            r_last_t   <= '0;
        end else if (i_en && i_ctrl.op == OP_UPD) begin
            r_dterm    <= 17'(r_err) - 17'(r_prev_err);
            r_prev_err <= r_err;
            r_last_t   <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_err <= i_line_error;
            r_ml  <= i_speed_left;
            r_mr  <= i_speed_right;
            r_now <= i_now_ms;
        end
        if (i_en) begin
            case (i_ctrl.op)
                OP_TEST: begin
                    r_prod <= mul_p;
                    r_upd  <= due;
                    r_side <= 1'b0;
                    r_sat  <= 1'b0;
                end
                OP_MULKD: begin
                    r_pid  <= PID_W'(r_prod);
                    r_prod <= mul_p;
                end
                OP_PID: begin
                    r_pid <= r_pid + PID_W'(r_prod);
                end
                OP_SUM: begin
                    r_acc <= ACC_W'(sum);
                end
                OP_SCALE: begin
                    r_acc <= scaled;
                end
                OP_CLAMP: begin
                    if (r_side) begin
                        r_drv_r <= clamped[DRV_W-1:0];
                    end else begin
                        r_drv_l <= clamped[DRV_W-1:0];
                    end
                    r_sat  <= r_sat | clip;
                    r_side <= ~r_side;
                end
                OP_OUT: begin
                    r_out_l   <= r_drv_l;
                    r_out_r   <= r_drv_r;
                    r_out_upd <= r_upd;
                    r_out_sat <= r_sat;
                end
                default: begin
                    r_side <= r_side;
                end
            endcase
        end
    end

    assign o_stat          = '{due: due, side: r_side};
    assign o_drive_left    = r_out_l;
    assign o_drive_right   = r_out_r;
    assign o_deriv_updated = r_out_upd;
    assign o_saturated     = r_out_sat;

endmodule

// ===== rtl/pd_differential_drive_mixer_core.sv =====
// Top level of the differential-drive PD mixer.
// Each transfer on the input channel is run by an eight-step microcode program on one
// shared 17x17 multiplier and a 48-bit accumulator: a derivative refresh test (plus one
// update step when the refresh is due), the two gain products, then sum, x220 scale and
// truncate/clamp once per wheel. An item keeps the block busy until its last step, and a new
// item can be taken in the cycle after that step; the result sits in an output register, so
// the next item starts while it waits, and the final step stalls only if the previous
// result has still not been taken.
module pd_differential_drive_mixer_core #(
    parameter int DERIV_INTERVAL_CAP = 190,
    parameter int DRIVE_LIMIT        = 1000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pdm_pkg::IDX_W-1:0]         i_cfg_idx,
    input  logic [pdm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [15:0]                i_line_error,
    input  logic signed [15:0]                i_speed_left,
    input  logic signed [15:0]                i_speed_right,
    input  logic [31:0]                       i_now_ms,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pdm_pkg::DRV_W-1:0]  o_drive_left,
    output logic signed [pdm_pkg::DRV_W-1:0]  o_drive_right,
    output logic                              o_deriv_updated,
    output logic                              o_saturated
);
    import pdm_pkg::*;

    t_ctrl ctrl;
    t_stat stat;
    logic  en, busy, load, hold;
    logic  r_out_valid, n_out_valid;

    assign o_in_ready = !busy;
    assign load       = i_in_valid && !busy;
    assign hold       = r_out_valid && !i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (en && ctrl.op == OP_OUT) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    pdm_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (load),
        .i_hold  (hold),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_en    (en),
        .o_busy  (busy)
    );

    pdm_dp #(
        .DERIV_INTERVAL_CAP (DERIV_INTERVAL_CAP),
        .DRIVE_LIMIT        (DRIVE_LIMIT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_load          (load),
        .i_line_error    (i_line_error),
        .i_speed_left    (i_speed_left),
        .i_speed_right   (i_speed_right),
        .i_now_ms        (i_now_ms),
        .i_ctrl          (ctrl),
        .i_en            (en),
        .o_stat          (stat),
        .o_drive_left    (o_drive_left),
        .o_drive_right   (o_drive_right),
        .o_deriv_updated (o_deriv_updated),
        .o_saturated     (o_saturated)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the differential-drive PD mixer core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pdm_pkg::*;

    localparam int DERIV_CAP   = 190;
    localparam int DRIVE_LIM   = 1000;
    localparam int SETTLE      = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int NPHASE      = 8;
    localparam int PHASE_ITEMS = 50;
    localparam int NROWS       = 25;
    localparam int MAX_LINES   = 40;

    typedef struct packed {
        logic signed [DRV_W-1:0] left;
        logic signed [DRV_W-1:0] right;
        logic                    upd;
        logic                    sat;
    } t_drive;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [IDX_W-1:0]   idx;
        logic [CFG_W-1:0]   data;
        logic signed [15:0] err;
        logic signed [15:0] sl;
        logic signed [15:0] sr;
        logic [31:0]        now;
        bit                 typed;
        t_drive             want;
    } t_row;

    localparam t_drive NO_EXP = '0;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [15:0]      i_line_error = '0;
    logic signed [15:0]      i_speed_left = '0;
    logic signed [15:0]      i_speed_right = '0;
    logic [31:0]             i_now_ms = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [DRV_W-1:0] o_drive_left;
    logic signed [DRV_W-1:0] o_drive_right;
    logic                    o_deriv_updated;
    logic                    o_saturated;

    pd_differential_drive_mixer_core #(
        .DERIV_INTERVAL_CAP(DERIV_CAP),
        .DRIVE_LIMIT       (DRIVE_LIM)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_line_error   (i_line_error),
        .i_speed_left   (i_speed_left),
        .i_speed_right  (i_speed_right),
        .i_now_ms       (i_now_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_drive_left   (o_drive_left),
        .o_drive_right  (o_drive_right),
        .o_deriv_updated(o_deriv_updated),
        .o_saturated    (o_saturated)
    );

    always #10 i_clk = ~i_clk;

    // Mixer state and register copies
    logic [CFG_W-1:0]   gain_p;
    logic [CFG_W-1:0]   gain_d;
    logic [CFG_W-1:0]   base_spd;
    logic [CFG_W-1:0]   deriv_ivl;
    logic signed [15:0] held_error;
    logic signed [16:0] held_slope;
    logic [31:0]        held_time;

    t_drive expected_drives[$];
    int     mismatch_count = 0;
    bit     in_idle_on = 1'b1;
    bit     out_idle_on = 1'b1;
    int     ready_hold = 0;
    int     quiet_cycles = 0;
    logic [31:0] last_now = '0;
    t_row   stim_table[NROWS];

    function automatic longint clamp_drive(input longint q, output bit hit);
        longint v;
        v = q / 65536;
        hit = 1'b0;
        if (v > DRIVE_LIM) begin
            hit = 1'b1;
            v = DRIVE_LIM;
        end else if (v < -DRIVE_LIM) begin
            hit = 1'b1;
            v = -DRIVE_LIM;
        end
        return v;
    endfunction

    function automatic t_drive predict_drive(input logic signed [15:0] err,
                                             input logic signed [15:0] sl,
                                             input logic signed [15:0] sr,
                                             input logic [31:0] now);
        logic [31:0] ivl;
        logic [31:0] due;
        longint      pid, base, tl, tr, dl, dr;
        bit          hit_l, hit_r;
        t_drive      r;
        ivl = (deriv_ivl > DERIV_CAP) ? 32'(DERIV_CAP) : 32'(deriv_ivl);
        due = held_time + ivl;
        r.upd = 1'b0;
        if (due < now) begin
            held_slope = err - held_error;
            held_error = err;
            held_time  = now;
            r.upd      = 1'b1;
        end
        pid  = longint'(gain_p) * longint'(err) + longint'(gain_d) * longint'(held_slope);
        base = longint'(base_spd) * 256;
        tl   = 2 * (base + pid) - longint'(sl) * 256;
        tr   = 2 * (base - pid) - longint'(sr) * 256;
        dl   = clamp_drive(220 * tl + 50 * 65536 + 220 * pid, hit_l);
        dr   = clamp_drive(220 * tr + 50 * 65536 - 220 * pid, hit_r);
        r.left  = dl[DRV_W-1:0];
        r.right = dr[DRV_W-1:0];
        r.sat   = hit_l | hit_r;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_LINES) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            REG_PROP_GAIN:  gain_p    = data;
            REG_DERIV_GAIN: gain_d    = data;
            REG_BASE_SPEED: base_spd  = data;
            REG_DERIV_IVL:  deriv_ivl = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Hold the sender until every result is back, then settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_drives.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic send_sample(input logic signed [15:0] err,
                               input logic signed [15:0] sl,
                               input logic signed [15:0] sr,
                               input logic [31:0] now,
                               input bit typed,
                               input t_drive want);
        t_drive p;
        if (in_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_line_error  = err;
        i_speed_left  = sl;
        i_speed_right = sr;
        i_now_ms      = now;
        do @(posedge i_clk); while (!o_in_ready);
        p = predict_drive(err, sl, sr, now);
        expected_drives.push_back(typed ? want : p);
    endtask

    always @(negedge i_clk) begin
        if (!out_idle_on) begin
            i_out_ready = 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_hold  = $urandom_range(1, 18) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_drive w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_drives.size() == 0) begin
                report_mismatch($sformatf("unexpected result L=%0d R=%0d",
                                          o_drive_left, o_drive_right));
            end else begin
                w = expected_drives.pop_front();
                if (o_drive_left !== w.left)
                    report_mismatch($sformatf("drive_left got %0d want %0d",
                                              o_drive_left, w.left));
                if (o_drive_right !== w.right)
                    report_mismatch($sformatf("drive_right got %0d want %0d",
                                              o_drive_right, w.right));
                if (o_deriv_updated !== w.upd)
                    report_mismatch($sformatf("deriv_updated got %0b want %0b",
                                              o_deriv_updated, w.upd));
                if (o_saturated !== w.sat)
                    report_mismatch($sformatf("saturated got %0b want %0b",
                                              o_saturated, w.sat));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("pd_differential_drive_mixer_core verification failed");
            $finish;
        end
    end

    initial begin
        logic signed [15:0] err, sl, sr;
        logic [31:0]        now;
        bit                 small_mode;
        t_row               row;

        gain_p     = PROP_GAIN_RST;
        gain_d     = DERIV_GAIN_RST;
        base_spd   = BASE_SPEED_RST;
        deriv_ivl  = DERIV_IVL_RST;
        held_error = '0;
        held_slope = '0;
        held_time  = '0;

        stim_table = '{
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b1,
              '{11'sd1000, 11'sd1000, 1'b0, 1'b1}},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd0, 16'sd32767, 16'sd32767, 32'd0, 1'b1,
              '{-11'sd1000, -11'sd1000, 1'b0, 1'b1}},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd0, -16'sd32768, -16'sd32768, 32'd0, 1'b1,
              '{11'sd1000, 11'sd1000, 1'b0, 1'b1}},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd0, 16'sd0, 16'sd0, 32'd1, 1'b1,
              '{11'sd1000, 11'sd1000, 1'b1, 1'b1}},
            '{ROW_CFG, REG_PROP_GAIN, 16'd0, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_CFG, REG_BASE_SPEED, 16'd0, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, -16'sd32768, 16'sd0, 16'sd0, 32'd1, 1'b1,
              '{11'sd50, 11'sd50, 1'b0, 1'b0}},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd32767, 16'sd0, 16'sd0, 32'd2, 1'b1,
              '{11'sd50, 11'sd50, 1'b1, 1'b0}},
            '{ROW_CFG, REG_BASE_SPEED, 16'd256, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd0, 16'sd256, 16'sd256, 32'd2, 1'b1,
              '{11'sd270, 11'sd270, 1'b0, 1'b0}},
            '{ROW_CFG, REG_DERIV_GAIN, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_CFG, REG_PROP_GAIN, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, -16'sd32768, 16'sd0, 16'sd0, 32'd3, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd32767, 16'sd32767, -16'sd32768, 32'd4, 1'b0,
              NO_EXP},
            '{ROW_CFG, REG_DERIV_IVL, 16'hFFFF, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd100, 16'sd10, -16'sd10, 32'd194, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd100, 16'sd10, -16'sd10, 32'd195, 1'b0, NO_EXP},
            '{ROW_CFG, REG_DERIV_IVL, 16'd0, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, -16'sd5, 16'sd0, 16'sd0, 32'hFFFF_FFF0, 1'b0,
              NO_EXP},
            '{ROW_CFG, REG_DERIV_IVL, 16'd190, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd7, 16'sd0, 16'sd0, 32'h0000_00AE, 1'b0,
              NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, 16'sd7, 16'sd0, 16'sd0, 32'h0000_00AF, 1'b0,
              NO_EXP},
            '{ROW_CFG, REG_DERIV_IVL, 16'd191, 16'sd0, 16'sd0, 16'sd0, 32'd0, 1'b0, NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, -16'sd1, 16'sd0, 16'sd0, 32'h0000_016D, 1'b0,
              NO_EXP},
            '{ROW_ITEM, REG_PROP_GAIN, 16'd0, -16'sd1, 16'sd0, 16'sd0, 32'h0000_016E, 1'b0,
              NO_EXP}
        };

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_table[k]) begin
            row = stim_table[k];
            if (row.kind == ROW_CFG) begin
                wait_drained();
                write_reg(row.idx, row.data);
            end else begin
                send_sample(row.err, row.sl, row.sr, row.now, row.typed, row.want);
            end
        end
        last_now = 32'h0000_016E;

        for (int ph = 0; ph < NPHASE; ph++) begin
            wait_drained();
            small_mode  = (ph >= 2) && (ph % 2 == 0);
            in_idle_on  = (ph < NPHASE - 2) && (ph != 3);
            out_idle_on = (ph < NPHASE - 2) && (ph != 3);
            if (ph == 0) begin
                write_reg(REG_PROP_GAIN, 16'hFFFF);
                write_reg(REG_DERIV_GAIN, 16'hFFFF);
                write_reg(REG_BASE_SPEED, 16'hFFFF);
                write_reg(REG_DERIV_IVL, 16'hFFFF);
            end else if (ph == 1) begin
                write_reg(REG_PROP_GAIN, 16'h0000);
                write_reg(REG_DERIV_GAIN, 16'h0000);
                write_reg(REG_BASE_SPEED, 16'h0000);
                write_reg(REG_DERIV_IVL, 16'h0000);
            end else if (small_mode) begin
                write_reg(REG_PROP_GAIN, 16'($urandom_range(0, 255)));
                write_reg(REG_DERIV_GAIN, 16'($urandom_range(0, 255)));
                write_reg(REG_BASE_SPEED, 16'($urandom_range(0, 512)));
                write_reg(REG_DERIV_IVL, 16'($urandom_range(0, 300)));
            end else begin
                write_reg(REG_PROP_GAIN, 16'($urandom()));
                write_reg(REG_DERIV_GAIN, 16'($urandom()));
                write_reg(REG_BASE_SPEED, 16'($urandom()));
                write_reg(REG_DERIV_IVL,
                          ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 400))
                                                      : 16'($urandom()));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 2 && n == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                if (small_mode) begin
                    err = 16'($urandom_range(0, 512) - 256);
                    sl  = 16'($urandom_range(0, 1024) - 512);
                    sr  = 16'($urandom_range(0, 1024) - 512);
                end else begin
                    err = 16'($urandom());
                    sl  = 16'($urandom());
                    sr  = 16'($urandom());
                end
                if ($urandom_range(0, 6) == 0) begin
                    now = $urandom();
                end else begin
                    now = last_now + 32'($urandom_range(0, 250));
                end
                last_now = now;
                send_sample(err, sl, sr, now, 1'b0, NO_EXP);
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("pd_differential_drive_mixer_core verification clean");
        end else begin
            $display("pd_differential_drive_mixer_core verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pdm_pkg.sv
rtl/pdm_seq.sv
rtl/pdm_dp.sv
rtl/pd_differential_drive_mixer_core.sv
test/tb_top.sv
